/* rtl/core/bitmap_frame_allocator_unit_macros.svh */
// Assertion macros shared by the frame allocator RTL.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfa assertion failed");

`endif

/* rtl/core/bfa_pkg.sv */
// Shared constants, types and helper functions of the frame allocator.
`default_nettype none

package bfa_pkg;

  localparam int FRAMES     = 16384;
  localparam int PAGE_BYTES = 4096;
  localparam int WORD_BITS  = 64;

  localparam int ADDR_W     = 32;
  localparam int FA_W       = 26;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int FIDX_W     = $clog2(FRAMES);
  localparam int FRAME_W    = FIDX_W + 1;
  localparam int WORD_SHIFT = $clog2(WORD_BITS);
  localparam int WORDS      = FRAMES / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORDS);
  localparam int MPG_W      = ADDR_W - PAGE_SHIFT;
  localparam int PG_W       = MPG_W + 1;

  // Pages taken by the bitmap itself, placed right after the rounded start.
  localparam int BITMAP_PAGES = (FRAMES / 8 + PAGE_BYTES - 1) / PAGE_BYTES;

  localparam logic [MODE_W-1:0] MODE_INIT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_END   = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic                  found;
    logic [WORD_SHIFT-1:0] idx;
  } zero_find_t;

  // Lowest clear bit of a bitmap word.
  function automatic zero_find_t first_zero(input word_t w);
    zero_find_t r;
    r.found = ~&w;
    r.idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.idx = WORD_SHIFT'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bfa_channels.sv */
// Handshake channel interfaces of the frame allocator.
`default_nettype none

interface bfa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bfa_pkg::CFG_IDX_W-1:0]  index;
  logic [bfa_pkg::ADDR_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface bfa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bfa_pkg::MODE_W-1:0]  mode;
  logic [bfa_pkg::ADDR_W-1:0]  address;
  modport source (output valid, output mode, output address, input ready);
  modport sink (input valid, input mode, input address, output ready);
endinterface

interface bfa_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [bfa_pkg::FA_W-1:0]  frame_address;
  logic                      ok;
  modport source (output valid, output frame_address, output ok, input ready);
  modport sink (input valid, input frame_address, input ok, output ready);
endinterface

`default_nettype wire

/* rtl/core/bfa_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output      logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bitmap_frame_allocator_unit.sv */
// Top level of the bitmap page frame allocator: sequencer, registers and bitmap RAM.
// Init computes the layout, then writes the whole bitmap, one bitmap word per cycle.
// Alloc checks one bitmap word per cycle; an empty window answers without a scan.
// Reserve reads, modifies and writes one bitmap word; an unused mode answers without touching the bitmap.
// One transaction is in work at a time; a new one is taken while the result waits.
// Reset clears control and configuration; allocation finds nothing until the first init.
`default_nettype none
`include "bitmap_frame_allocator_unit_macros.svh"

module bitmap_frame_allocator_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  bfa_cfg_if.sink    cfg,
  bfa_req_if.sink    req,
  bfa_rsp_if.source  rsp
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT0  = 4'd1;
  localparam logic [3:0] S_INIT1  = 4'd2;
  localparam logic [3:0] S_INIT2  = 4'd3;
  localparam logic [3:0] S_SWEEP  = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_RES_RD = 4'd6;
  localparam logic [3:0] S_RES_WR = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0] state;

  // Configuration registers.
  logic [bfa_pkg::ADDR_W-1:0] memory_start;
  logic [bfa_pkg::ADDR_W-1:0] memory_end;
  logic [bfa_pkg::ADDR_W-1:0] module_start;
  logic [bfa_pkg::ADDR_W-1:0] module_end;

  // Layout of the frame map, set by init.
  logic [bfa_pkg::FRAME_W-1:0] first_frame;
  logic [bfa_pkg::FRAME_W-1:0] frame_limit;

  // Intermediate values of the init computation.
  logic [bfa_pkg::PG_W-1:0]    page_start;
  logic [bfa_pkg::ADDR_W-1:0]  mod_span;
  logic                        mod_nonempty;
  logic [bfa_pkg::PG_W-1:0]    mod_count;
  logic [bfa_pkg::MPG_W-1:0]   mod_base;
  logic [bfa_pkg::FRAME_W-1:0] mod_lo;
  logic [bfa_pkg::FRAME_W-1:0] mod_hi;
  logic [bfa_pkg::WORD_AW-1:0] sweep_ptr;

  // Scan pipeline: one word issued to the RAM and one word checked per cycle.
  logic [bfa_pkg::WORD_AW-1:0] issue_ptr;
  logic [bfa_pkg::WORD_AW-1:0] last_word;
  logic                        issue_more;
  logic                        chk_vld;
  logic [bfa_pkg::WORD_AW-1:0] chk_idx;

  // Reserve target and the pending result.
  logic [bfa_pkg::FIDX_W-1:0]  hold_frame;
  logic [bfa_pkg::FIDX_W-1:0]  res_frame;
  logic                        res_ok;

  // Output register.
  logic                        rsp_valid;
  logic [bfa_pkg::FA_W-1:0]    rsp_fa;
  logic                        rsp_ok;

  // Bitmap RAM ports; a set bit marks a used frame.
  logic                        ram_we;
  logic [bfa_pkg::WORD_AW-1:0] ram_wa;
  bfa_pkg::word_t              ram_wd;
  logic                        ram_re;
  logic [bfa_pkg::WORD_AW-1:0] ram_ra;
  bfa_pkg::word_t              ram_rd;

  bfa_pkg::zero_find_t         zf;
  bfa_pkg::word_t              sweep_word;
  logic [bfa_pkg::FRAME_W-1:0] lim_m1;
  logic [bfa_pkg::FIDX_W-1:0]  found_frame;
  logic [bfa_pkg::PG_W:0]      ff_sum;
  logic [bfa_pkg::PG_W:0]      mod_sum;
  logic                        req_fire;
  logic                        scan_hit;
  logic                        res_in_map;

  bfa_ram #(
    .WIDTH (bfa_pkg::WORD_BITS),
    .DEPTH (bfa_pkg::WORDS)
  ) u_map (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  assign cfg.ready         = 1'b1;
  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.frame_address = rsp_fa;
  assign rsp.ok            = rsp_ok;

  assign req_fire    = req.valid && req.ready;
  assign zf          = bfa_pkg::first_zero(ram_rd);
  assign scan_hit    = (state == S_SCAN) && chk_vld && zf.found;
  assign found_frame = {chk_idx, zf.idx};
  assign lim_m1      = frame_limit - bfa_pkg::FRAME_W'(1);
  assign ff_sum      = {1'b0, page_start} + (bfa_pkg::PG_W + 1)'(bfa_pkg::BITMAP_PAGES);
  assign mod_sum     = {2'b00, mod_base} + {1'b0, mod_count};
  // A reserve address lands in the map when its frame number is below the map size.
  assign res_in_map  = (req.address[bfa_pkg::ADDR_W-1:bfa_pkg::PAGE_SHIFT+bfa_pkg::FIDX_W] == '0);

  // Init value of one bitmap word: a frame is free only inside the usable
  // range and outside the boot module's frames.
  always_comb begin
    logic [bfa_pkg::FRAME_W-1:0] lf;
    lf = '0;
    for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
      lf = bfa_pkg::FRAME_W'({sweep_ptr, bfa_pkg::WORD_SHIFT'(i)});
      sweep_word[i] = !((lf >= first_frame) && (lf < frame_limit)) ||
                      ((lf >= mod_lo) && (lf < mod_hi));
    end
  end

  // RAM access selection. During a scan the write of a found word and the
  // read of the next word never touch the same address.
  always_comb begin
    ram_we = 1'b0;
    ram_wa = sweep_ptr;
    ram_wd = sweep_word;
    case (state)
      S_SWEEP: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        ram_we = scan_hit;
        ram_wa = chk_idx;
        ram_wd = ram_rd | (bfa_pkg::WORD_BITS'(1) << zf.idx);
      end
      S_RES_WR: begin
        ram_we = 1'b1;
        ram_wa = hold_frame[bfa_pkg::FIDX_W-1:bfa_pkg::WORD_SHIFT];
        ram_wd = ram_rd | (bfa_pkg::WORD_BITS'(1) << hold_frame[bfa_pkg::WORD_SHIFT-1:0]);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_re = ((state == S_SCAN) && issue_more) || (state == S_RES_RD);
  assign ram_ra = (state == S_RES_RD) ? hold_frame[bfa_pkg::FIDX_W-1:bfa_pkg::WORD_SHIFT]
                                      : issue_ptr;

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_start <= '0;
      memory_end   <= '0;
      module_start <= '0;
      module_end   <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        bfa_pkg::REG_MEMORY_START: memory_start <= cfg.data;
        bfa_pkg::REG_MEMORY_END:   memory_end   <= cfg.data;
        bfa_pkg::REG_MODULE_START: module_start <= cfg.data;
        bfa_pkg::REG_MODULE_END:   module_end   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      first_frame <= '0;
      frame_limit <= '0;
      issue_more  <= 1'b0;
      chk_vld     <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      // A result loaded in S_RESP in this same cycle takes precedence.
      if (rsp_valid && rsp.ready && (state != S_RESP)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            res_frame <= '0;
            res_ok    <= (req.mode == bfa_pkg::MODE_RESERVE) && res_in_map;
            case (req.mode)
              bfa_pkg::MODE_INIT: begin
                state <= S_INIT0;
              end
              bfa_pkg::MODE_ALLOC: begin
                // An empty range (including the state before any init)
                // finds nothing without touching the bitmap.
                if (first_frame < frame_limit) begin
                  issue_ptr  <= first_frame[bfa_pkg::FIDX_W-1:bfa_pkg::WORD_SHIFT];
                  last_word  <= lim_m1[bfa_pkg::FIDX_W-1:bfa_pkg::WORD_SHIFT];
                  issue_more <= 1'b1;
                  chk_vld    <= 1'b0;
                  state      <= S_SCAN;
                end else begin
                  state <= S_RESP;
                end
              end
              bfa_pkg::MODE_RESERVE: begin
                if (res_in_map) begin
                  hold_frame <= req.address[bfa_pkg::PAGE_SHIFT+bfa_pkg::FIDX_W-1:
                                            bfa_pkg::PAGE_SHIFT];
                  state      <= S_RES_RD;
                end else begin
                  state <= S_RESP;
                end
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end

        // Round the memory start up to a page, take the limit page and
        // the module span.
        S_INIT0: begin
          page_start <= bfa_pkg::PG_W'(({1'b0, memory_start} +
                        (bfa_pkg::ADDR_W + 1)'(bfa_pkg::PAGE_BYTES - 1)) >> bfa_pkg::PAGE_SHIFT);
          if (memory_end[bfa_pkg::ADDR_W-1:bfa_pkg::PAGE_SHIFT] >=
              bfa_pkg::MPG_W'(bfa_pkg::FRAMES)) begin
            frame_limit <= bfa_pkg::FRAME_W'(bfa_pkg::FRAMES);
          end else begin
            frame_limit <= memory_end[bfa_pkg::PAGE_SHIFT+bfa_pkg::FRAME_W-1:
                                      bfa_pkg::PAGE_SHIFT];
          end
          mod_nonempty <= module_end > module_start;
          mod_span     <= module_end - module_start;
          state        <= S_INIT1;
        end

        // Skip the bitmap pages and count the module's pages.
        S_INIT1: begin
          if (ff_sum >= (bfa_pkg::PG_W + 1)'(bfa_pkg::FRAMES)) begin
            first_frame <= bfa_pkg::FRAME_W'(bfa_pkg::FRAMES);
          end else begin
            first_frame <= ff_sum[bfa_pkg::FRAME_W-1:0];
          end
          mod_count <= bfa_pkg::PG_W'(({1'b0, mod_span} +
                       (bfa_pkg::ADDR_W + 1)'(bfa_pkg::PAGE_BYTES - 1)) >> bfa_pkg::PAGE_SHIFT);
          mod_base  <= module_start[bfa_pkg::ADDR_W-1:bfa_pkg::PAGE_SHIFT];
          state     <= S_INIT2;
        end

        // Clamp the module's frame range to the map; an empty range marks nothing.
        S_INIT2: begin
          if (!mod_nonempty) begin
            mod_lo <= '0;
            mod_hi <= '0;
          end else begin
            if (mod_base >= bfa_pkg::MPG_W'(bfa_pkg::FRAMES)) begin
              mod_lo <= bfa_pkg::FRAME_W'(bfa_pkg::FRAMES);
            end else begin
              mod_lo <= mod_base[bfa_pkg::FRAME_W-1:0];
            end
            if (mod_sum >= (bfa_pkg::PG_W + 1)'(bfa_pkg::FRAMES)) begin
              mod_hi <= bfa_pkg::FRAME_W'(bfa_pkg::FRAMES);
            end else begin
              mod_hi <= mod_sum[bfa_pkg::FRAME_W-1:0];
            end
          end
          sweep_ptr <= '0;
          state     <= S_SWEEP;
        end

        S_SWEEP: begin
          if (sweep_ptr == bfa_pkg::WORD_AW'(bfa_pkg::WORDS - 1)) begin
            res_ok <= 1'b1;
            state  <= S_RESP;
          end else begin
            sweep_ptr <= sweep_ptr + bfa_pkg::WORD_AW'(1);
          end
        end

        // Words outside the free range were written all used at init, so the
        // first clear bit in the scanned words is the lowest free frame.
        S_SCAN: begin
          if (scan_hit) begin
            res_frame  <= found_frame;
            res_ok     <= 1'b1;
            issue_more <= 1'b0;
            chk_vld    <= 1'b0;
            state      <= S_RESP;
          end else if (chk_vld && (chk_idx == last_word)) begin
            issue_more <= 1'b0;
            chk_vld    <= 1'b0;
            state      <= S_RESP;
          end else begin
            if (issue_more) begin
              issue_ptr <= issue_ptr + bfa_pkg::WORD_AW'(1);
            end
            issue_more <= issue_more && (issue_ptr != last_word);
            chk_vld    <= issue_more;
            chk_idx    <= issue_ptr;
          end
        end

        S_RES_RD: begin
          state <= S_RES_WR;
        end

        S_RES_WR: begin
          state <= S_RESP;
        end

        // Hand the result to the output register once it is free.
        S_RESP: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_fa    <= bfa_pkg::FA_W'({res_frame, {bfa_pkg::PAGE_SHIFT{1'b0}}});
            rsp_ok    <= res_ok;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted transaction always makes the block busy, so it is not ready right after.
  `BFA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_fire, !req.ready)
  // The bitmap is only written while a transaction is in work.
  `BFA_ASSERT_NOW(a_write_in_work, clk, rst, ram_we, (state != S_IDLE) && (state != S_RESP))
  // A found frame lies inside the allocatable range.
  `BFA_ASSERT_NOW(a_alloc_in_range, clk, rst, scan_hit,
    ({1'b0, found_frame} >= first_frame) && ({1'b0, found_frame} < frame_limit))
  // The layout never points past the map.
  `BFA_ASSERT_NOW(a_layout_bounds, clk, rst, 1'b1,
    (first_frame <= bfa_pkg::FRAME_W'(bfa_pkg::FRAMES)) &&
    (frame_limit <= bfa_pkg::FRAME_W'(bfa_pkg::FRAMES)))

endmodule

`default_nettype wire
